// ===== hdl/apf_pkg.sv =====
// Package for the articulation point finder: sizes, state encoding and
// controller/datapath command and status structs. Depends on nothing.
`default_nettype none
package apf_pkg;
  localparam int MAX_NODES_DEF = 64;
  localparam int MAX_EDGES_DEF = 256;
  localparam int NODE_W = 6;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PUSH0,
    ST_EDGE,
    ST_LOOK,
    ST_SCAN,
    ST_PARENT,
    ST_EMIT,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic store_edge;
    logic push_root;
    logic read_edge;
    logic look;
    logic scan;
    logic pop;
    logic parent_upd;
    logic finish;
    logic emit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic pos_done;
    logic last_frame;
    logic emit_last;
    logic clear_done;
  } status_t;
endpackage
`default_nettype wire

// ===== hdl/apf_datapath.sv =====
// Datapath of the articulation point finder: edge memory, per-node tables,
// search stack and output registers. Depends on apf_pkg.
`default_nettype none
module apf_datapath #(
  parameter int MAX_NODES = apf_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = apf_pkg::MAX_EDGES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [apf_pkg::NODE_W-1:0] node_a,
  input  wire logic [apf_pkg::NODE_W-1:0] node_b,
  input  wire apf_pkg::cmd_t             cmd,
  output apf_pkg::status_t               status,
  output logic                           result_valid,
  output logic [apf_pkg::NODE_W-1:0]     node_index,
  output logic                           is_cut,
  output logic                           last_node,
  output logic                           edges_dropped
);
  localparam int NW = apf_pkg::NODE_W;
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int TW = $clog2(MAX_NODES + 2);
  localparam int SW = $clog2(MAX_NODES + 1);
  localparam int SAW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int NEFF = (MAX_NODES < (1 << NW)) ? MAX_NODES : (1 << NW);
  localparam int XW = $clog2(NEFF);

  // One search frame. The top frame lives in registers; the frames below it
  // are kept in the stack memory.
  typedef struct packed {
    logic [NW-1:0] node;
    logic [NW-1:0] parent;
    logic          has_parent;
    logic [EW-1:0] pos;
    logic [CW-1:0] children;
    logic [TW-1:0] low;
    logic [TW-1:0] disc;
  } frame_t;

  logic [2*NW-1:0] edge_mem [MAX_EDGES];
  logic [2*NW-1:0] edge_rd;
  logic [EW-1:0]   edge_count;
  logic [NW:0]     node_count;
  logic            overflow_seen;

  // A discovery time of zero marks a node not yet visited.
  logic [TW-1:0]   disc_mem [MAX_NODES];
  logic [TW-1:0]   disc_rd;
  logic            cut_mem  [MAX_NODES];
  logic            cut_rd;
  logic [TW-1:0]   visit_clock;

  frame_t          stk_mem [MAX_NODES];
  frame_t          frame_rd;
  frame_t          cur;
  frame_t          saved;
  logic [SW-1:0]   depth;
  logic [TW-1:0]   popped_low;

  logic [NW-1:0]   idx;
  logic [NW-1:0]   ea, eb, v;
  logic            hit, in_range, fresh, push_ok, set_cut;
  logic            accept_edge;
  logic [NW:0]     top_node;
  logic [NW:0]     n_eff;
  logic [TW-1:0]   new_disc;

  assign ea = edge_rd[2*NW-1:NW];
  assign eb = edge_rd[NW-1:0];
  assign hit = (ea == cur.node) || (eb == cur.node);
  assign v = (ea == cur.node) ? eb : ea;
  assign in_range = ({1'b0, v} < (NW+1)'(MAX_NODES));
  assign fresh = hit && in_range && (disc_rd == '0);
  assign push_ok = fresh && (depth < SW'(MAX_NODES));
  assign new_disc = visit_clock + 1'b1;
  assign set_cut = frame_rd.has_parent ? (popped_low >= frame_rd.disc)
                                       : (frame_rd.children > CW'(1));
  assign accept_edge = ({1'b0, node_a} < (NW+1)'(MAX_NODES)) &&
                       ({1'b0, node_b} < (NW+1)'(MAX_NODES)) &&
                       (edge_count < EW'(MAX_EDGES));
  assign top_node = (node_a > node_b) ? {1'b0, node_a} + 1'b1 : {1'b0, node_b} + 1'b1;
  assign n_eff = (node_count == '0) ? (NW+1)'(1) : node_count;

  always_comb begin
    saved = cur;
    saved.children = cur.children + 1'b1;
  end

  assign status.pos_done   = (cur.pos >= edge_count);
  assign status.last_frame = (depth == SW'(1));
  assign status.emit_last  = ({1'b0, idx} + 1'b1 >= n_eff);
  assign status.clear_done = (idx == NW'(NEFF - 1));

  always_ff @(posedge clk) begin
    if (cmd.read_edge) begin
      edge_rd <= edge_mem[EAW'(cur.pos)];
    end
    if (cmd.store_edge && accept_edge) begin
      edge_mem[EAW'(edge_count)] <= {node_a, node_b};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      disc_rd <= disc_mem[XW'(v)];
    end
    if (cmd.push_root) begin
      disc_mem[0] <= TW'(1);
    end else if (cmd.scan && push_ok) begin
      disc_mem[XW'(v)] <= new_disc;
    end else if (cmd.clear) begin
      disc_mem[XW'(idx)] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      cut_rd <= cut_mem[0];
    end else if (cmd.emit) begin
      cut_rd <= cut_mem[XW'(idx + 1'b1)];
    end
    if (cmd.parent_upd && set_cut) begin
      cut_mem[XW'(frame_rd.node)] <= 1'b1;
    end else if (cmd.clear) begin
      cut_mem[XW'(idx)] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      frame_rd <= stk_mem[SAW'(depth - SW'(2))];
    end
    if (cmd.scan && push_ok) begin
      stk_mem[SAW'(depth - SW'(1))] <= saved;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count    <= '0;
      node_count    <= '0;
      overflow_seen <= 1'b0;
      visit_clock   <= '0;
      depth         <= '0;
      idx           <= '0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cmd.store_edge) begin
        if (accept_edge) begin
          edge_count <= edge_count + 1'b1;
          if (top_node > node_count) begin
            node_count <= top_node;
          end
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (cmd.push_root) begin
        visit_clock     <= TW'(1);
        cur.node        <= '0;
        cur.parent      <= '0;
        cur.has_parent  <= 1'b0;
        cur.pos         <= '0;
        cur.children    <= '0;
        cur.low         <= TW'(1);
        cur.disc        <= TW'(1);
        depth           <= SW'(1);
        idx             <= '0;
      end
      if (cmd.read_edge) begin
        cur.pos <= cur.pos + 1'b1;
      end
      if (cmd.scan && hit && in_range) begin
        if (fresh) begin
          if (push_ok) begin
            visit_clock    <= new_disc;
            cur.node       <= v;
            cur.parent     <= cur.node;
            cur.has_parent <= 1'b1;
            cur.pos        <= '0;
            cur.children   <= '0;
            cur.low        <= new_disc;
            cur.disc       <= new_disc;
            depth          <= depth + 1'b1;
          end else begin
            cur.children <= cur.children + 1'b1;
          end
        end else if (!(cur.has_parent && v == cur.parent)) begin
          if (disc_rd < cur.low) begin
            cur.low <= disc_rd;
          end
        end
      end
      if (cmd.pop) begin
        popped_low <= cur.low;
        depth      <= depth - 1'b1;
      end
      if (cmd.parent_upd) begin
        cur.node       <= frame_rd.node;
        cur.parent     <= frame_rd.parent;
        cur.has_parent <= frame_rd.has_parent;
        cur.pos        <= frame_rd.pos;
        cur.children   <= frame_rd.children;
        cur.disc       <= frame_rd.disc;
        cur.low        <= (popped_low < frame_rd.low) ? popped_low : frame_rd.low;
      end
      if (cmd.emit) begin
        result_valid  <= 1'b1;
        node_index    <= idx;
        is_cut        <= ({1'b0, idx} < (NW+1)'(MAX_NODES)) && cut_rd;
        last_node     <= status.emit_last;
        edges_dropped <= overflow_seen;
        idx           <= status.emit_last ? '0 : idx + 1'b1;
      end
      if (cmd.clear) begin
        if (status.clear_done) begin
          idx           <= '0;
          edge_count    <= '0;
          node_count    <= '0;
          overflow_seen <= 1'b0;
          visit_clock   <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/apf_control.sv =====
// Controller state machine of the articulation point finder.
// Depends on apf_pkg.
`default_nettype none
module apf_control (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             last_edge,
  input  wire apf_pkg::status_t status,
  output apf_pkg::cmd_t         cmd,
  output logic                  busy
);
  apf_pkg::state_t state, state_next;

  // Reset leads into the clearing pass, since the node tables start unknown.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apf_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != apf_pkg::ST_LOAD);
    case (state)
      apf_pkg::ST_LOAD: begin
        if (start) begin
          cmd.store_edge = 1'b1;
          if (last_edge) begin
            state_next = apf_pkg::ST_PUSH0;
          end
        end
      end
      apf_pkg::ST_PUSH0: begin
        cmd.push_root = 1'b1;
        state_next = apf_pkg::ST_EDGE;
      end
      apf_pkg::ST_EDGE: begin
        if (status.pos_done) begin
          if (status.last_frame) begin
            cmd.finish = 1'b1;
            state_next = apf_pkg::ST_EMIT;
          end else begin
            cmd.pop = 1'b1;
            state_next = apf_pkg::ST_PARENT;
          end
        end else begin
          cmd.read_edge = 1'b1;
          state_next = apf_pkg::ST_LOOK;
        end
      end
      apf_pkg::ST_LOOK: begin
        cmd.look = 1'b1;
        state_next = apf_pkg::ST_SCAN;
      end
      apf_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        state_next = apf_pkg::ST_EDGE;
      end
      apf_pkg::ST_PARENT: begin
        cmd.parent_upd = 1'b1;
        state_next = apf_pkg::ST_EDGE;
      end
      apf_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.emit_last) begin
          state_next = apf_pkg::ST_CLEAR;
        end
      end
      apf_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_next = apf_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = apf_pkg::ST_LOAD;
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/articulation_point_finder.sv =====
// Top level of the articulation point finder: controller and datapath.
// Depends on apf_pkg, apf_control and apf_datapath.
//
// Edges are taken one item per cycle while busy is low; each is stored in
// an edge memory, or dropped and flagged if the memory is full or a node
// index is out of range. The item with last_edge set is stored too and
// starts a depth-first search from node 0 after a state that sets up the
// root. Every node reached from node 0 gets a frame that rescans the edge
// memory: for each stored edge one step reads the edge, one reads the
// discovery time of its far end and one updates the search. Each return
// to a parent frame pops the stack and then updates the parent, and the
// walk ends when the root is exhausted. One result per node, from zero to
// the highest index seen, then follows on consecutive cycles, marked by
// result_valid; the receiver cannot stall these. A clearing pass over every
// node table entry (64 by default) follows before busy falls again, and the
// same pass runs straight after reset, so busy stays high until it ends.
`default_nettype none
module articulation_point_finder #(
  parameter int MAX_NODES = apf_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = apf_pkg::MAX_EDGES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [apf_pkg::NODE_W-1:0] node_a,
  input  wire logic [apf_pkg::NODE_W-1:0] node_b,
  input  wire logic                      last_edge,
  output logic                           result_valid,
  output logic [apf_pkg::NODE_W-1:0]     node_index,
  output logic                           is_cut,
  output logic                           last_node,
  output logic                           edges_dropped
);
  apf_pkg::cmd_t    cmd;
  apf_pkg::status_t status;

  apf_control u_ctrl (
    .clk(clk), .rst(rst), .start(start), .last_edge(last_edge),
    .status(status), .cmd(cmd), .busy(busy)
  );

  apf_datapath #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk(clk), .rst(rst), .node_a(node_a), .node_b(node_b),
    .cmd(cmd), .status(status), .result_valid(result_valid),
    .node_index(node_index), .is_cut(is_cut), .last_node(last_node),
    .edges_dropped(edges_dropped)
  );
endmodule
`default_nettype wire

// ===== hdl/apf_checker.sv =====
// Port-level checks for the articulation point finder, bound to the top.
// Depends on nothing beyond the top level's ports.
`default_nettype none
module apf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       last_edge,
  input wire logic       result_valid,
  input wire logic [5:0] node_index,
  input wire logic       last_node
);
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result while idle");
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last_edge) |=> busy) else $error("search not started");
  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !$past(result_valid)) |-> node_index == 6'd0)
    else $error("results not from node zero");
  a_ascend: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_node) |=> result_valid &&
      node_index == $past(node_index) + 6'd1) else $error("result gap");
endmodule

bind articulation_point_finder apf_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .last_edge(last_edge),
  .result_valid(result_valid), .node_index(node_index), .last_node(last_node)
);
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for articulation_point_finder: drives edge items,
// predicts the cut flags with its own depth-first search and checks every result.
// Depends on apf_pkg and the articulation_point_finder RTL.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_LIMIT = 64;
  localparam int EDGE_LIMIT = 256;
  // The slowest graph walks a full edge memory once per node, so the watchdog
  // allows several times as long as that walk.
  localparam int STALL_LIMIT = 400000;
  localparam int TAIL_CYCLES = 300;

  typedef logic [apf_pkg::NODE_W-1:0] node_t;

  // One edge item as the driver presents it. The drain flag makes the driver
  // hold this item back until every expected result has arrived.
  typedef struct {
    node_t a;
    node_t b;
    logic  last;
    bit    drain;
  } edge_item_t;

  typedef struct {
    node_t idx;
    logic  cut;
    logic  last;
    logic  dropped;
  } node_report_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  node_t node_a = '0;
  node_t node_b = '0;
  logic  last_edge = 1'b0;
  logic  busy;
  logic  result_valid;
  node_t node_index;
  logic  is_cut;
  logic  last_node;
  logic  edges_dropped;

  articulation_point_finder dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .node_a(node_a), .node_b(node_b), .last_edge(last_edge),
    .result_valid(result_valid), .node_index(node_index), .is_cut(is_cut),
    .last_node(last_node), .edges_dropped(edges_dropped)
  );

  edge_item_t   pending_edges[$];
  node_report_t expected_reports[$];
  int           errors = 0;
  int           accepted_items = 0;
  int           stall_cycles = 0;

  // Shadow copy of the block's graph state.
  node_t       shadow_a[EDGE_LIMIT];
  node_t       shadow_b[EDGE_LIMIT];
  int          shadow_edges = 0;
  int          shadow_nodes = 0;
  bit          shadow_overflow = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Stores one edge or flags an overflow and, on the final edge of a graph,
  // runs an iterative depth-first search from node 0 and queues one report per node.
  function automatic void predict_cut_nodes(node_t a, node_t b, logic lst);
    int disc[NODE_LIMIT];
    int low[NODE_LIMIT];
    bit seen[NODE_LIMIT];
    bit cut[NODE_LIMIT];
    int fr_node[NODE_LIMIT];
    int fr_par[NODE_LIMIT];
    bit fr_has_par[NODE_LIMIT];
    int fr_pos[NODE_LIMIT];
    int fr_kids[NODE_LIMIT];
    int sp;
    int stamp;
    int u;
    int v;
    int pu;
    int i;
    int n;
    node_report_t r;
    if (shadow_edges < EDGE_LIMIT) begin
      shadow_a[shadow_edges] = a;
      shadow_b[shadow_edges] = b;
      shadow_edges++;
      if ((a > b ? int'(a) : int'(b)) + 1 > shadow_nodes)
        shadow_nodes = (a > b ? int'(a) : int'(b)) + 1;
    end else begin
      shadow_overflow = 1'b1;
    end
    if (!lst) return;

    for (int k = 0; k < NODE_LIMIT; k++) begin
      seen[k] = 1'b0;
      cut[k] = 1'b0;
      disc[k] = 0;
      low[k] = 0;
    end
    // The root frame.
    stamp = 1;
    seen[0] = 1'b1;
    disc[0] = 1;
    low[0] = 1;
    fr_node[0] = 0;
    fr_par[0] = 0;
    fr_has_par[0] = 1'b0;
    fr_pos[0] = 0;
    fr_kids[0] = 0;
    sp = 1;
    while (sp > 0) begin
      u = fr_node[sp-1];
      if (fr_pos[sp-1] >= shadow_edges) begin
        // Frame exhausted: fold its low link into the parent and test the
        // parent for being a cut vertex.
        sp--;
        if (sp > 0) begin
          pu = fr_node[sp-1];
          if (low[u] < low[pu]) low[pu] = low[u];
          if (fr_has_par[sp-1]) begin
            if (low[u] >= disc[pu]) cut[pu] = 1'b1;
          end else if (fr_kids[sp-1] > 1) begin
            cut[pu] = 1'b1;
          end
        end
      end else begin
        i = fr_pos[sp-1];
        fr_pos[sp-1]++;
        v = -1;
        if (shadow_a[i] == u) v = shadow_b[i];
        else if (shadow_b[i] == u) v = shadow_a[i];
        if (v >= 0) begin
          if (!seen[v]) begin
            fr_kids[sp-1]++;
            stamp++;
            seen[v] = 1'b1;
            disc[v] = stamp;
            low[v] = stamp;
            fr_node[sp] = v;
            fr_par[sp] = u;
            fr_has_par[sp] = 1'b1;
            fr_pos[sp] = 0;
            fr_kids[sp] = 0;
            sp++;
          end else if (!(fr_has_par[sp-1] && v == fr_par[sp-1])) begin
            if (disc[v] < low[u]) low[u] = disc[v];
          end
        end
      end
    end

    n = (shadow_nodes == 0) ? 1 : shadow_nodes;
    for (int k = 0; k < n; k++) begin
      r.idx = node_t'(k);
      r.cut = cut[k];
      r.last = (k + 1 == n);
      r.dropped = shadow_overflow;
      expected_reports.insert(expected_reports.size(), r);
    end
    shadow_edges = 0;
    shadow_nodes = 0;
    shadow_overflow = 1'b0;
  endfunction

  // Driver: an item is taken at an edge where start is high and busy is low.
  // The next item, or an idle cycle, is then chosen.
  always @(posedge clk) begin : driver
    bit         taken;
    bit         hold_off;
    int         idle_pct;
    edge_item_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        predict_cut_nodes(node_a, node_b, last_edge);
        void'(pending_edges.pop_front());
        accepted_items++;
      end
      if (start && !taken) begin
        // Item still waiting for the block: keep it on the ports.
      end else begin
        if (accepted_items < 120) idle_pct = 17;
        else if (accepted_items < 240) idle_pct = 87;
        else idle_pct = 0;
        hold_off = (pending_edges.size() == 0) ||
                   ($urandom_range(99) < idle_pct);
        if (!hold_off && pending_edges[0].drain && expected_reports.size() != 0)
          hold_off = 1'b1;
        if (hold_off) begin
          start <= 1'b0;
        end else begin
          nxt = pending_edges[0];
          start <= 1'b1;
          node_a <= nxt.a;
          node_b <= nxt.b;
          last_edge <= nxt.last;
        end
      end
    end
  end

  // Monitor: each strobed result is checked against the oldest expectation.
  always @(posedge clk) begin : monitor
    node_report_t want;
    if (!rst && result_valid) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result node %0d cut %0b last %0b dropped %0b",
                 $realtime, node_index, is_cut, last_node, edges_dropped);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        if (node_index !== want.idx) begin
          $display("%0t: node_index expected %0d actual %0d",
                   $realtime, want.idx, node_index);
          errors++;
        end
        if (is_cut !== want.cut) begin
          $display("%0t: is_cut (node %0d) expected %0b actual %0b",
                   $realtime, want.idx, want.cut, is_cut);
          errors++;
        end
        if (last_node !== want.last) begin
          $display("%0t: last_node (node %0d) expected %0b actual %0b",
                   $realtime, want.idx, want.last, last_node);
          errors++;
        end
        if (edges_dropped !== want.dropped) begin
          $display("%0t: edges_dropped (node %0d) expected %0b actual %0b",
                   $realtime, want.idx, want.dropped, edges_dropped);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither an item nor a result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired", $realtime);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic add_edge(int a, int b, bit lst, bit drain = 1'b0);
    edge_item_t it;
    it.a = node_t'(a);
    it.b = node_t'(b);
    it.last = lst;
    it.drain = drain;
    pending_edges.insert(pending_edges.size(), it);
  endtask

  // A random graph: mostly a spanning tree from node 0 over a few nodes with
  // extra edges, sometimes pure noise edges that may leave nodes unreachable.
  task automatic add_random_graph();
    int span;
    int extra;
    int pick;
    bit noise;
    pick = $urandom_range(99);
    if (pick < 60) span = $urandom_range(2, 8);
    else if (pick < 90) span = $urandom_range(9, 20);
    else span = 64;
    noise = ($urandom_range(99) < 20);
    extra = $urandom_range(0, 6);
    if (noise) begin
      for (int k = 0; k < extra + 2; k++)
        add_edge($urandom_range(span - 1), $urandom_range(span - 1), 1'b0);
    end else begin
      for (int k = 1; k < span; k++) begin
        // Keep larger spans short by letting some tree nodes go missing.
        if (span < 30 || $urandom_range(3) == 0)
          add_edge(k, $urandom_range(k - 1), 1'b0);
      end
      for (int k = 0; k < extra; k++)
        add_edge($urandom_range(span - 1), $urandom_range(span - 1), 1'b0);
    end
    add_edge($urandom_range(span - 1), $urandom_range(span - 1), 1'b1);
  endtask

  initial begin
    // Directed graphs.
    add_edge(0, 0, 1'b1);                                 // lone self loop, one node
    add_edge(0, 63, 1'b1);                                // widest index, 64 results
    add_edge(0, 1, 1'b0); add_edge(1, 2, 1'b1);           // path: middle is cut
    add_edge(1, 0, 1'b0); add_edge(0, 2, 1'b1);           // root with two children
    add_edge(0, 1, 1'b0); add_edge(1, 2, 1'b0);
    add_edge(2, 0, 1'b1);                                 // triangle: no cut
    add_edge(0, 1, 1'b0); add_edge(1, 0, 1'b0);
    add_edge(1, 1, 1'b0); add_edge(1, 2, 1'b1);           // parallel edges, self loop
    add_edge(0, 1, 1'b0); add_edge(42, 21, 1'b0);
    add_edge(62, 61, 1'b1);                               // unreachable nodes
    // Overflow: the store fills, further edges are dropped. The driver first
    // waits for every outstanding result.
    add_edge(0, 1, 1'b0, 1'b1);
    for (int k = 1; k < EDGE_LIMIT + 3; k++)
      add_edge($urandom_range(15), $urandom_range(15), 1'b0);
    add_edge(3, 4, 1'b1);
    // A second full graph after the overflow checks the flag was cleared.
    add_edge(5, 0, 1'b1, 1'b1);
    while (pending_edges.size() < 360) add_random_graph();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending_edges.size() != 0 || start || expected_reports.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
